// ----- src/rxsort_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsort_pkg
// Types, key codes and the key select function shared by the sorter modules.
// ----------------------------------------------------------------------------
package rxsort_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KEY_AGE   = 2'd0;
  localparam logic [1:0] KEY_IQ    = 2'd1;
  localparam logic [1:0] KEY_MONEY = 2'd2;
  localparam logic [1:0] KEY_SPARE = 2'd3;

  typedef struct packed {
    logic [15:0] money;
    logic [7:0]  iq;
    logic [7:0]  age;
  } rec_t;

  typedef struct packed {
    rec_t rec;
    logic store;
    logic last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDI,
    ST_RDJ,
    ST_CMP,
    ST_WRI,
    ST_ORD,
    ST_OLD
  } state_t;

  function automatic logic [15:0] key_of(input rec_t rec, input logic [1:0] key);
    logic [15:0] k;
    case (key)
      KEY_AGE:   k = {8'h00, rec.age};
      KEY_IQ:    k = {8'h00, rec.iq};
      KEY_MONEY: k = rec.money;
      default:   k = {8'h00, rec.age};
    endcase
    return k;
  endfunction

endpackage

// ----- src/rxsort_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsort_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rxsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rxsort_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsort_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rxsort_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  rxsort_pkg::cmd_t   din,
  output logic               full,
  input  logic               rd,
  output rxsort_pkg::cmd_t   dout,
  output logic               empty
);

  rxsort_pkg::cmd_t                  slots [rxsort_pkg::QUEUE_DEPTH];
  logic [rxsort_pkg::QUEUE_AW-1:0]   wptr;
  logic [rxsort_pkg::QUEUE_AW-1:0]   rptr;
  logic [rxsort_pkg::QUEUE_AW:0]     fill;
  logic                              do_wr;
  logic                              do_rd;

  assign full  = (fill == (rxsort_pkg::QUEUE_AW + 1)'(rxsort_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/rxsort_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsort_front
// Accepts records and tags each as stored or dropped, tracking batch fill.
// ----------------------------------------------------------------------------
module rxsort_front #(
  parameter int MAX_RECORDS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rxsort_pkg::rec_t  rec,
  input  logic              last_record,
  output logic              q_wr,
  output rxsort_pkg::cmd_t  q_din,
  input  logic              q_full
);

  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic [CW-1:0] fcount;
  logic          store;

  assign full        = q_full;
  assign q_wr        = push && !q_full;
  assign store       = (fcount < CW'(MAX_RECORDS));
  assign q_din.rec   = rec;
  assign q_din.store = store;
  assign q_din.last  = last_record;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
    end else if (q_wr) begin
      if (last_record) begin
        fcount <= '0;
      end else if (store) begin
        fcount <= fcount + 1'b1;
      end
    end
  end

endmodule

// ----- src/rxsort_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsort_back
// Stores records, runs the exchange sort over the record RAM, streams results.
// ----------------------------------------------------------------------------
module rxsort_back #(
  parameter int MAX_RECORDS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_we,
  input  logic [1:0]        key_data,
  input  rxsort_pkg::cmd_t  cmd,
  input  logic              q_empty,
  output logic              q_rd,
  output rxsort_pkg::rec_t  out_rec,
  output logic              out_last,
  output logic              out_ovf,
  output logic              out_valid,
  input  logic              out_pop
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  rxsort_pkg::state_t state;
  rxsort_pkg::state_t state_next;

  logic [1:0]       sort_key;
  logic [CW-1:0]    count;
  logic [CW-1:0]    n;
  logic             ovf;
  logic [AW-1:0]    i;
  logic [AW-1:0]    j;
  logic [AW-1:0]    k;
  rxsort_pkg::rec_t cur;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;
  rxsort_pkg::rec_t rd_rec;

  logic [CW-1:0]    n_fin;
  logic             swap;
  logic             j_end;
  logic             i_end;
  logic             k_end;
  logic             out_free;
  logic             load_out;

  rxsort_ram #(
    .WIDTH (32),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec   = rxsort_pkg::rec_t'(ram_rdata);
  assign n_fin    = count + CW'(cmd.store);
  assign swap     = rxsort_pkg::key_of(cur, sort_key) > rxsort_pkg::key_of(rd_rec, sort_key);
  assign j_end    = (CW'(j) + 1'b1) == n;
  assign i_end    = (CW'(i) + CW'(2)) >= n;
  assign k_end    = (CW'(k) + 1'b1) == n;
  assign out_free = !out_valid || out_pop;

  always_comb begin
    state_next = state;
    case (state)
      rxsort_pkg::ST_IDLE: begin
        if (!q_empty && cmd.last) begin
          state_next = (n_fin < CW'(2)) ? rxsort_pkg::ST_ORD : rxsort_pkg::ST_RDI;
        end
      end
      rxsort_pkg::ST_RDI: state_next = rxsort_pkg::ST_RDJ;
      rxsort_pkg::ST_RDJ: state_next = rxsort_pkg::ST_CMP;
      rxsort_pkg::ST_CMP: begin
        if (j_end) begin
          state_next = rxsort_pkg::ST_WRI;
        end
      end
      rxsort_pkg::ST_WRI: begin
        state_next = i_end ? rxsort_pkg::ST_ORD : rxsort_pkg::ST_RDJ;
      end
      rxsort_pkg::ST_ORD: state_next = rxsort_pkg::ST_OLD;
      rxsort_pkg::ST_OLD: begin
        if (out_free) begin
          state_next = k_end ? rxsort_pkg::ST_IDLE : rxsort_pkg::ST_ORD;
        end
      end
      default: state_next = rxsort_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_rd      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = j;
    ram_wdata = cur;
    ram_raddr = k;
    load_out  = 1'b0;
    case (state)
      rxsort_pkg::ST_IDLE: begin
        q_rd      = !q_empty;
        ram_we    = !q_empty && cmd.store;
        ram_waddr = count[AW-1:0];
        ram_wdata = cmd.rec;
      end
      rxsort_pkg::ST_RDI: ram_raddr = i;
      rxsort_pkg::ST_RDJ: ram_raddr = j;
      rxsort_pkg::ST_CMP: begin
        ram_raddr = j + 1'b1;
        ram_we    = swap;
        ram_waddr = j;
      end
      rxsort_pkg::ST_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i;
        ram_raddr = i + 1'b1;
      end
      rxsort_pkg::ST_ORD: ram_raddr = k;
      rxsort_pkg::ST_OLD: begin
        ram_raddr = k;
        load_out  = out_free;
      end
      default: ram_raddr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rxsort_pkg::ST_IDLE;
      sort_key  <= rxsort_pkg::KEY_AGE;
      count     <= '0;
      n         <= '0;
      ovf       <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (key_we) begin
        sort_key <= key_data;
      end
      case (state)
        rxsort_pkg::ST_IDLE: begin
          if (!q_empty) begin
            if (!cmd.store) begin
              ovf <= 1'b1;
            end
            if (cmd.last) begin
              n     <= n_fin;
              count <= '0;
              i     <= '0;
              j     <= AW'(1);
              k     <= '0;
            end else if (cmd.store) begin
              count <= count + 1'b1;
            end
          end
        end
        rxsort_pkg::ST_CMP: begin
          j <= j + 1'b1;
        end
        rxsort_pkg::ST_WRI: begin
          i <= i + 1'b1;
          j <= i + AW'(2);
        end
        rxsort_pkg::ST_OLD: begin
          if (out_free) begin
            k <= k + 1'b1;
            if (k_end) begin
              ovf <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rxsort_pkg::ST_RDJ) begin
      cur <= rd_rec;
    end else if (state == rxsort_pkg::ST_CMP && swap) begin
      cur <= rd_rec;
    end
    if (load_out) begin
      out_rec  <= rd_rec;
      out_last <= k_end;
      out_ovf  <= ovf;
    end
  end

endmodule

// ----- src/record_exchange_sort_by_key.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key
// Loads a batch of records and streams them out sorted by the selected field.
// ----------------------------------------------------------------------------
// Input channel: push/full with age, iq, money, last_record. A record is
// taken when push is high and full is low; one record per cycle while the
// four-entry command queue has room. last_record closes the batch. Records
// past MAX_RECORDS are dropped and flagged on every result of the batch.
// Result channel: empty/pop. While empty is low the oldest sorted record is
// on out_age/out_iq/out_money with out_last on the final one; pop takes it.
// Sorting a batch of n >= 2 records runs one RAM compare per cycle; each
// result then goes through the ORD and OLD states, set by the single
// read port of the record RAM. The next batch keeps loading into the queue
// meanwhile. A stalled receiver holds the current result and pauses the
// stream; nothing is lost. sort_key_we writes sort_key (0 age, 1 iq,
// 2 money, 3 age) and is meant for idle time. rst clears the queue, batch
// counters and key; stored records need no clearing.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_key #(
  parameter int MAX_RECORDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sort_key_we,
  input  logic [1:0]  sort_key_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  age,
  input  logic [7:0]  iq,
  input  logic [15:0] money,
  input  logic        last_record,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_age,
  output logic [7:0]  out_iq,
  output logic [15:0] out_money,
  output logic        out_last,
  output logic        overflowed
);

  rxsort_pkg::rec_t in_rec;
  rxsort_pkg::rec_t out_rec;
  rxsort_pkg::cmd_t q_din;
  rxsort_pkg::cmd_t q_dout;
  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  logic             out_valid;

  assign in_rec.age   = age;
  assign in_rec.iq    = iq;
  assign in_rec.money = money;

  rxsort_front #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .rec         (in_rec),
    .last_record (last_record),
    .q_wr        (q_wr),
    .q_din       (q_din),
    .q_full      (q_full)
  );

  rxsort_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_rd),
    .dout  (q_dout),
    .empty (q_empty)
  );

  rxsort_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .key_we    (sort_key_we),
    .key_data  (sort_key_data),
    .cmd       (q_dout),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .out_rec   (out_rec),
    .out_last  (out_last),
    .out_ovf   (overflowed),
    .out_valid (out_valid),
    .out_pop   (pop)
  );

  assign empty     = !out_valid;
  assign out_age   = out_rec.age;
  assign out_iq    = out_rec.iq;
  assign out_money = out_rec.money;

endmodule
